@@ src/emm_pkg.sv @@
// Shared constants, register codes and unit interface types of the dry/wet mixer.
package emm_pkg;

   // Sample and arithmetic widths.
   localparam int SAMPLE_BITS = 24;
   localparam int POWER_BITS  = 2 * SAMPLE_BITS;
   localparam int LEVEL_BITS  = 17;
   localparam int COEF_BITS   = 16;
   localparam int LAT_BITS    = 14;
   localparam int CORR_BITS   = 18;
   localparam int QUOT_BITS   = 34;
   localparam int REM_BITS    = POWER_BITS + 2;
   localparam int CSR_BITS    = 17;

   // Default depth of the dry delay line.
   localparam int DEFAULT_DELAY_DEPTH = 16384;

   // Unity in Q1.16 and the correction ceiling in Q2.16.
   localparam logic [LEVEL_BITS-1:0] ONE_Q16  = 17'd65536;
   localparam logic [CORR_BITS-1:0]  CORR_MAX = 18'd131072;

   // Power floor for the wet envelope: 1e-12 of full scale power, at least one LSB.
   localparam longint unsigned EPS_RAW = (64'd1 << (POWER_BITS - 2)) / 64'd1000000000000;
   localparam logic [POWER_BITS-1:0] EPS = (EPS_RAW == 0) ? POWER_BITS'(1) : POWER_BITS'(EPS_RAW);

   // Reset values of the configuration registers.
   localparam logic [COEF_BITS-1:0]  ATTACK_RESET    = 16'd65000;
   localparam logic [COEF_BITS-1:0]  RELEASE_RESET   = 16'd65420;
   localparam logic [LEVEL_BITS-1:0] FADE_STEP_RESET = 17'd136;
   localparam logic [LEVEL_BITS-1:0] MIX_STEP_RESET  = 17'd68;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_LATENCY,
      CSR_ATTACK,
      CSR_RELEASE,
      CSR_WET_BLEND,
      CSR_MATCH_ENABLE,
      CSR_BYPASS,
      CSR_FADE_STEP,
      CSR_MIX_STEP
   } csr_index_type;

   // Request to the ratio and square root unit.
   typedef struct packed {
      logic                  start;
      logic [POWER_BITS-1:0] de;
      logic [POWER_BITS-1:0] den;
   } emm_ratio_req_type;

   // Answer of the ratio and square root unit.
   typedef struct packed {
      logic                 done;
      logic [CORR_BITS-1:0] corr;
   } emm_ratio_rsp_type;

endpackage

@@ src/emm_ratio.sv @@
// Iterative divider and square root that form the envelope correction gain.
module emm_ratio import emm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  emm_ratio_req_type req,
   output emm_ratio_rsp_type rsp
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_ROOT
   } state_type;

   localparam int STEP_BITS = $clog2(QUOT_BITS);

   state_type               state_ff;
   logic [STEP_BITS-1:0]    step_ff;
   logic [REM_BITS-1:0]     rem_ff;
   logic [POWER_BITS-1:0]   den_ff;
   logic [QUOT_BITS-1:0]    quot_ff;
   logic [QUOT_BITS-1:0]    rad_ff;
   logic [QUOT_BITS-1:0]    root_ff;
   logic [QUOT_BITS-1:0]    bit_ff;
   logic                    done_ff;
   logic [CORR_BITS-1:0]    corr_ff;

   logic [REM_BITS-1:0]     den4;
   logic [REM_BITS-1:0]     div_cmp;
   logic [REM_BITS-1:0]     rem_sh;
   logic                    div_ge;
   logic [REM_BITS-1:0]     rem_in;
   logic [QUOT_BITS-1:0]    quot_in;
   logic [QUOT_BITS-1:0]    trial;
   logic                    root_ge;
   logic [QUOT_BITS-1:0]    root_in;
   logic                    done_in;

   // A ratio of four or more saturates the correction at once.
   assign den4 = {req.den, 2'b00};

   // A result is ready after a saturated ratio or after the last root step.
   assign done_in = ((state_ff == ST_IDLE) && req.start && ({2'b00, req.de} >= den4))
                 || ((state_ff == ST_ROOT) && bit_ff[0]);

   // One quotient bit per cycle; the two integer bits compare without a shift.
   always_comb begin
      div_cmp = (step_ff == '0) ? {1'b0, den_ff, 1'b0} : {2'b00, den_ff};
      rem_sh  = (step_ff < STEP_BITS'(2)) ? rem_ff : {rem_ff[REM_BITS-2:0], 1'b0};
      div_ge  = rem_sh >= div_cmp;
      rem_in  = div_ge ? rem_sh - div_cmp : rem_sh;
      quot_in = {quot_ff[QUOT_BITS-2:0], div_ge};
   end

   // One root bit per cycle, restoring digit by digit.
   always_comb begin
      trial   = root_ff + bit_ff;
      root_ge = rad_ff >= trial;
      root_in = root_ge ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);
   end

   // Sequencer: idle, long division, then square root.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= done_in;
         case (state_ff)
            ST_IDLE: begin
               if (req.start) begin
                  if ({2'b00, req.de} >= den4) begin
                     corr_ff <= CORR_MAX;
                  end else begin
                     rem_ff   <= {2'b00, req.de};
                     den_ff   <= req.den;
                     step_ff  <= '0;
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               rem_ff  <= rem_in;
               quot_ff <= quot_in;
               step_ff <= step_ff + STEP_BITS'(1);
               if (step_ff == STEP_BITS'(QUOT_BITS - 1)) begin
                  rad_ff   <= quot_in;
                  root_ff  <= '0;
                  bit_ff   <= QUOT_BITS'(1) << (QUOT_BITS - 2);
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (root_ge) begin
                  rad_ff <= rad_ff - trial;
               end
               root_ff <= root_in;
               bit_ff  <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  corr_ff  <= root_in[CORR_BITS-1:0];
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.corr = corr_ff;

endmodule

@@ src/envelope_matched_dry_wet_mixer_core.sv @@
// Top level of the envelope-matched dry/wet mixer with its delay line and sequencer.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tdata: dry_sample, wet_sample; tuser: restart
//   rsp      out        rsp_tvalid/rsp_tready  tdata: out_sample
//   csr      in         csr_wen                csr_index, csr_wdata
//
// One transaction at a time: between acceptance and result it waits on the 34-step
// divider and 17-step square root; a saturated ratio skips both, and a bypassed
// transaction goes straight to the output step. Reset is synchronous and needs no
// clearing pass: a fill count marks which delay line entries hold data since reset or
// restart. A result that waits on rsp_tready holds the sequencer in its last step; a
// new transaction is taken as soon as the previous result sits in the output register.
module envelope_matched_dry_wet_mixer_core import emm_pkg::*; #(
   parameter int DELAY_DEPTH = DEFAULT_DELAY_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [47:0]         req_tdata,   // [23:0] dry_sample, [47:24] wet_sample
   input  logic                req_tuser,   // [0] restart
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // [23:0] out_sample
   input  logic                csr_wen,
   input  logic [2:0]          csr_index,
   input  logic [CSR_BITS-1:0] csr_wdata
);

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int FW = $clog2(DELAY_DEPTH + 1);
   localparam int SB = SAMPLE_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DSQ,
      ST_WSQ,
      ST_DFOL,
      ST_WFOL,
      ST_ENVW,
      ST_RATIO_GO,
      ST_RATIO_WAIT,
      ST_GAIN,
      ST_GSUM,
      ST_T1,
      ST_T2,
      ST_T3,
      ST_FADE,
      ST_OUT
   } state_type;

   // Configuration registers.
   logic [LAT_BITS-1:0]   lat_ff;
   logic [COEF_BITS-1:0]  atk_ff;
   logic [COEF_BITS-1:0]  rel_ff;
   logic [LEVEL_BITS-1:0] wet_blend_ff;
   logic                  match_ff;
   logic                  bypass_ff;
   logic [LEVEL_BITS-1:0] fade_step_ff;
   logic [LEVEL_BITS-1:0] mix_step_ff;

   // Persistent state.
   logic [AW-1:0]         wp_ff;
   logic [FW-1:0]         fill_ff;
   logic [POWER_BITS-1:0] env_d_ff;
   logic [POWER_BITS-1:0] env_w_ff;
   logic [LEVEL_BITS-1:0] fade_lvl_ff;
   logic [LEVEL_BITS-1:0] wet_lvl_ff;
   logic [LEVEL_BITS-1:0] att_lvl_ff;

   // Per-transaction working registers.
   state_type             state_ff;
   logic                  byp_ff;
   logic                  lat0_ff;
   logic                  valid_ff;
   logic signed [SB-1:0]  dry_in_ff;
   logic signed [SB-1:0]  wet_ff;
   logic signed [SB-1:0]  mem_q_ff;
   logic signed [SB-1:0]  dry_d_ff;
   logic [POWER_BITS-1:0] pd_ff;
   logic [POWER_BITS-1:0] pw_ff;
   logic [CORR_BITS-1:0]  corr_ff;
   logic [CORR_BITS-1:0]  gain_ff;
   logic signed [58:0]    t1_ff;
   logic signed [42:0]    mixed_ff;
   logic signed [73:0]    prod_ff;
   logic                  rsp_tvalid_ff;
   logic [SB-1:0]         rsp_tdata_ff;

   // Delay line.
   logic [SB-1:0]         dline_mem [DELAY_DEPTH];

   logic                  accept;
   logic                  work;
   logic [AW-1:0]         wp_eff;
   logic [FW-1:0]         fill_eff;
   logic [AW-1:0]         lat_c;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wp_in;
   logic [FW-1:0]         fill_in;
   logic signed [SB-1:0]  dry_d;
   logic signed [48:0]    mul_a;
   logic signed [24:0]    mul_b;
   logic [COEF_BITS-1:0]  coef_d;
   logic [COEF_BITS-1:0]  coef_w;
   logic [POWER_BITS-1:0] env_fol;
   logic [LEVEL_BITS-1:0] wet_target;
   logic [34:0]           gain_sum;
   logic signed [58:0]    term;
   logic [58:0]           term_mag;
   logic [42:0]           term_rnd;
   logic signed [42:0]    mixed_in;
   logic signed [59:0]    fprod;
   logic [59:0]           fmag;
   logic [27:0]           frnd;
   logic signed [28:0]    y_wide;
   logic [SB-1:0]         y_sat;
   logic                  out_free;
   emm_ratio_req_type     ratio_req;
   emm_ratio_rsp_type     ratio_rsp;

   // Move a level toward its target by at most one step.
   function automatic logic [LEVEL_BITS-1:0] ramp_step(
      input logic [LEVEL_BITS-1:0] level,
      input logic [LEVEL_BITS-1:0] target,
      input logic [LEVEL_BITS-1:0] step
   );
      logic [LEVEL_BITS-1:0] diff;
      diff = '0;
      if (level < target) begin
         diff = target - level;
         return (diff > step) ? level + step : target;
      end
      if (level > target) begin
         diff = level - target;
         return (diff > step) ? level - step : target;
      end
      return level;
   endfunction

   assign accept   = req_tvalid && req_tready;
   assign work     = accept && !bypass_ff;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Delay line addressing after an optional restart.
   always_comb begin
      wp_eff   = req_tuser ? '0 : wp_ff;
      fill_eff = req_tuser ? '0 : fill_ff;
      lat_c    = (32'(lat_ff) >= 32'(DELAY_DEPTH)) ? AW'(DELAY_DEPTH - 1) : AW'(lat_ff);
      rd_addr  = (wp_eff >= lat_c) ? wp_eff - lat_c
                                   : AW'(32'(wp_eff) + 32'(DELAY_DEPTH) - 32'(lat_c));
      wp_in    = (32'(wp_eff) == DELAY_DEPTH - 1) ? '0 : wp_eff + AW'(1);
      fill_in  = (32'(fill_eff) == DELAY_DEPTH) ? fill_eff : fill_eff + FW'(1);
   end

   // Delay line write and registered read.
   always_ff @(posedge clock) begin
      if (work) begin
         dline_mem[wp_eff] <= req_tdata[SB-1:0];
         mem_q_ff          <= dline_mem[rd_addr];
      end
   end

   // Delayed dry sample: zero latency forwards, unwritten entries read as zero.
   assign dry_d = lat0_ff ? dry_in_ff : (valid_ff ? mem_q_ff : '0);

   assign coef_d     = (pd_ff > env_d_ff) ? atk_ff : rel_ff;
   assign coef_w     = (pw_ff > env_w_ff) ? atk_ff : rel_ff;
   assign wet_target = (wet_blend_ff > ONE_Q16) ? ONE_Q16 : wet_blend_ff;

   // Shared multiplier operands; the fade product is held while the result waits.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_DSQ: begin
            mul_a = 49'(dry_d);
            mul_b = 25'(dry_d);
         end
         ST_WSQ: begin
            mul_a = 49'(wet_ff);
            mul_b = 25'(wet_ff);
         end
         ST_DFOL: begin
            mul_a = $signed({1'b0, env_d_ff}) - $signed({1'b0, pd_ff});
            mul_b = $signed({9'b0, coef_d});
         end
         ST_WFOL: begin
            mul_a = $signed({1'b0, env_w_ff}) - $signed({1'b0, pw_ff});
            mul_b = $signed({9'b0, coef_w});
         end
         ST_GAIN: begin
            mul_a = $signed({32'b0, att_lvl_ff});
            mul_b = $signed({7'b0, corr_ff});
         end
         ST_GSUM: begin
            mul_a = 49'(dry_d_ff);
            mul_b = $signed({8'b0, ONE_Q16 - wet_lvl_ff});
         end
         ST_T1: begin
            mul_a = 49'(wet_ff);
            mul_b = $signed({8'b0, wet_lvl_ff});
         end
         ST_T2: begin
            mul_a = 49'($signed(prod_ff[41:0]));
            mul_b = $signed({7'b0, gain_ff});
         end
         ST_FADE, ST_OUT: begin
            mul_a = 49'(mixed_ff);
            mul_b = $signed({8'b0, fade_lvl_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 74'(mul_a * mul_b);
   end

   // Envelope follower sum: power*one + c*(env - power), rounded by 2^16.
   always_comb begin
      logic signed [65:0] fsum;
      logic [POWER_BITS-1:0] pwr;
      pwr     = (state_ff == ST_WFOL) ? pd_ff : pw_ff;
      fsum    = $signed({2'b00, pwr, 16'b0}) + prod_ff[65:0] + 66'sd32768;
      env_fol = fsum[63:16];
   end

   // Gain blend, mix rounding and final rounding with saturation.
   always_comb begin
      gain_sum = {2'b00, ONE_Q16 - att_lvl_ff, 16'b0} + {1'b0, prod_ff[33:0]} + 35'd32768;
      term     = t1_ff + prod_ff[58:0];
      term_mag = term[58] ? 59'(-term) : 59'(term);
      term_rnd = 43'((term_mag + 59'd32768) >> 16);
      mixed_in = term[58] ? -$signed(term_rnd) : $signed(term_rnd);
      fprod    = prod_ff[59:0];
      fmag     = fprod[59] ? 60'(-fprod) : 60'(fprod);
      frnd     = 28'((fmag + 60'd2147483648) >> 32);
      y_wide   = fprod[59] ? -$signed({1'b0, frnd}) : $signed({1'b0, frnd});
      if (y_wide > 29'sd8388607) begin
         y_sat = 24'h7FFFFF;
      end else if (y_wide < -29'sd8388608) begin
         y_sat = 24'h800000;
      end else begin
         y_sat = y_wide[SB-1:0];
      end
   end

   assign ratio_req.start = (state_ff == ST_RATIO_GO);
   assign ratio_req.de    = env_d_ff;
   assign ratio_req.den   = env_w_ff + EPS;

   emm_ratio u_ratio (
      .clock (clock),
      .reset (reset),
      .req   (ratio_req),
      .rsp   (ratio_rsp)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff       <= '0;
         atk_ff       <= ATTACK_RESET;
         rel_ff       <= RELEASE_RESET;
         wet_blend_ff <= ONE_Q16;
         match_ff     <= 1'b1;
         bypass_ff    <= 1'b0;
         fade_step_ff <= FADE_STEP_RESET;
         mix_step_ff  <= MIX_STEP_RESET;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_LATENCY:      lat_ff       <= csr_wdata[LAT_BITS-1:0];
            CSR_ATTACK:       atk_ff       <= csr_wdata[COEF_BITS-1:0];
            CSR_RELEASE:      rel_ff       <= csr_wdata[COEF_BITS-1:0];
            CSR_WET_BLEND:    wet_blend_ff <= csr_wdata[LEVEL_BITS-1:0];
            CSR_MATCH_ENABLE: match_ff     <= csr_wdata[0];
            CSR_BYPASS:       bypass_ff    <= csr_wdata[0];
            CSR_FADE_STEP:    fade_step_ff <= csr_wdata[LEVEL_BITS-1:0];
            CSR_MIX_STEP:     mix_step_ff  <= csr_wdata[LEVEL_BITS-1:0];
            default:          lat_ff       <= lat_ff;
         endcase
      end
   end

   // Sequencer with state updates and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         fill_ff       <= '0;
         env_d_ff      <= '0;
         env_w_ff      <= '0;
         fade_lvl_ff   <= ONE_Q16;
         wet_lvl_ff    <= ONE_Q16;
         att_lvl_ff    <= ONE_Q16;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // The output register fills from the last step and empties on a handshake.
         if ((state_ff == ST_OUT) && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  dry_in_ff <= req_tdata[SB-1:0];
                  wet_ff    <= req_tdata[2*SB-1:SB];
                  byp_ff    <= bypass_ff;
                  lat0_ff   <= (lat_c == '0);
                  valid_ff  <= (32'(lat_c) <= 32'(fill_eff));
                  if (bypass_ff) begin
                     state_ff <= ST_OUT;
                  end else begin
                     wp_ff   <= wp_in;
                     fill_ff <= fill_in;
                     if (req_tuser) begin
                        env_d_ff    <= '0;
                        env_w_ff    <= '0;
                        fade_lvl_ff <= '0;
                     end
                     state_ff <= ST_DSQ;
                  end
               end
            end
            ST_DSQ: begin
               dry_d_ff    <= dry_d;
               att_lvl_ff  <= ramp_step(att_lvl_ff, match_ff ? ONE_Q16 : '0, mix_step_ff);
               wet_lvl_ff  <= ramp_step(wet_lvl_ff, wet_target, mix_step_ff);
               fade_lvl_ff <= ramp_step(fade_lvl_ff, ONE_Q16, fade_step_ff);
               state_ff    <= ST_WSQ;
            end
            ST_WSQ: begin
               pd_ff    <= prod_ff[POWER_BITS-1:0];
               state_ff <= ST_DFOL;
            end
            ST_DFOL: begin
               pw_ff    <= prod_ff[POWER_BITS-1:0];
               state_ff <= ST_WFOL;
            end
            ST_WFOL: begin
               env_d_ff <= env_fol;
               state_ff <= ST_ENVW;
            end
            ST_ENVW: begin
               env_w_ff <= env_fol;
               state_ff <= ST_RATIO_GO;
            end
            ST_RATIO_GO: begin
               state_ff <= ST_RATIO_WAIT;
            end
            ST_RATIO_WAIT: begin
               if (ratio_rsp.done) begin
                  corr_ff  <= ratio_rsp.corr;
                  state_ff <= ST_GAIN;
               end
            end
            ST_GAIN: begin
               state_ff <= ST_GSUM;
            end
            ST_GSUM: begin
               gain_ff  <= gain_sum[33:16];
               state_ff <= ST_T1;
            end
            ST_T1: begin
               t1_ff    <= $signed({prod_ff[42:0], 16'b0});
               state_ff <= ST_T2;
            end
            ST_T2: begin
               state_ff <= ST_T3;
            end
            ST_T3: begin
               mixed_ff <= mixed_in;
               state_ff <= ST_FADE;
            end
            ST_FADE: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_tdata_ff <= byp_ff ? dry_in_ff : y_sat;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef NO_ASSERTIONS
   // The fade level never passes unity.
   a_fade_bound: assert property (@(posedge clock) disable iff (reset)
      fade_lvl_ff <= ONE_Q16)
      else $error("fade level above unity");

   // The ratio unit answers only while the sequencer waits for it.
   a_ratio_done: assert property (@(posedge clock) disable iff (reset)
      ratio_rsp.done |-> state_ff == ST_RATIO_WAIT)
      else $error("ratio result outside its wait step");

   // A finished result stays in the last step while the output register is full.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_tvalid_ff && !rsp_tready) |=> state_ff == ST_OUT)
      else $error("result dropped while output register full");

   // A restart transaction leaves one delay line entry filled and the dry envelope cleared.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser && !bypass_ff) |=> (fill_ff == FW'(1) && env_d_ff == '0))
      else $error("restart did not clear the dry path");
`endif

endmodule
